// ===== src/rvsde_pkg.sv =====
// Shared types and encodings for the RV32I subset decode and execute unit.
`timescale 1ns / 1ps

package rvsde_pkg;

  // Major opcodes.
  localparam logic [6:0] OP_R      = 7'b0110011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;

  // funct7 values for register-register operations.
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values for arithmetic and logic.
  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_SLT = 3'b010;
  localparam logic [2:0] F3_XOR = 3'b100;
  localparam logic [2:0] F3_OR  = 3'b110;
  localparam logic [2:0] F3_AND = 3'b111;

  // funct3 values for loads.
  localparam logic [2:0] F3_LB  = 3'b000;
  localparam logic [2:0] F3_LH  = 3'b001;
  localparam logic [2:0] F3_LW  = 3'b010;
  localparam logic [2:0] F3_LBU = 3'b100;
  localparam logic [2:0] F3_LHU = 3'b101;

  // funct3 values for stores.
  localparam logic [2:0] F3_SB = 3'b000;
  localparam logic [2:0] F3_SH = 3'b001;
  localparam logic [2:0] F3_SW = 3'b010;

  // funct3 values for branches.
  localparam logic [2:0] F3_BEQ = 3'b000;
  localparam logic [2:0] F3_BNE = 3'b001;
  localparam logic [2:0] F3_BLT = 3'b100;
  localparam logic [2:0] F3_BGE = 3'b101;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_OP    = 2'd1;
  localparam logic [1:0] ST_BAD_FUNCT = 2'd2;

  // Register file write request.
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } wr_t;

  // Outcome of executing one instruction.
  typedef struct packed {
    logic [31:0] alu;
    logic [4:0]  dest;
    logic        wr;
    logic        ld;
    logic        st;
    logic [31:0] sval;
    logic        taken;
    logic [1:0]  status;
  } res_t;

endpackage

// ===== src/rv32i_subset_decode_execute_unit.sv =====
// Top level of the RV32I subset decode and execute unit.
`timescale 1ns / 1ps
// A request is accepted into the execute register, and its result is registered in the
// output register when the execute stage advances.
// Throughput: one instruction per cycle unless the result is stalled; the register file memory
// is read once per request in the cycle of acceptance; the previous instruction's write is forwarded.
// A stalled result holds the execute stage, which stalls the input. Reset clears the program
// counter and the register valid bits at once, and the input is stalled while reset is high.

module rv32i_subset_decode_execute_unit #(
  parameter int REG_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               instr_valid,
  output logic               instr_stall,
  input  logic [31:0]        instruction,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        instr_address,
  output logic signed [31:0] alu_value,
  output logic [4:0]         dest_index,
  output logic               writes_reg,
  output logic               load_request,
  output logic               store_request,
  output logic signed [31:0] store_value,
  output logic               branch_taken,
  output logic [1:0]         status
);
  import rvsde_pkg::*;

  logic        e_valid;
  logic [31:0] e_instr;
  logic [31:0] pc;
  logic        e_adv;
  logic        in_take;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] next_pc;
  res_t        res;
  wr_t         wr;

  assign e_adv       = e_valid && (!result_valid || !result_stall);
  assign instr_stall = rst || (e_valid && !e_adv);
  assign in_take     = instr_valid && !instr_stall;

  assign wr.en   = e_adv && res.wr;
  assign wr.idx  = e_instr[11:7];
  assign wr.data = res.alu;

  rvsde_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk  (clk),
    .rst  (rst),
    .rd_en(in_take),
    .rs1  (instruction[19:15]),
    .rs2  (instruction[24:20]),
    .wr   (wr),
    .a    (a),
    .b    (b)
  );

  rvsde_exec #(
    .REG_COUNT(REG_COUNT)
  ) u_exec (
    .instr  (e_instr),
    .pc     (pc),
    .a      (a),
    .b      (b),
    .res    (res),
    .next_pc(next_pc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (in_take) begin
      e_valid <= 1'b1;
    end else if (e_adv) begin
      e_valid <= 1'b0;
    end
    if (in_take) begin
      e_instr <= instruction;
    end
  end

  // The program counter belongs to the execute stage, so a taken branch sets the address of
  // the next instruction that executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 32'd0;
    end else if (e_adv) begin
      pc <= next_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (e_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (e_adv) begin
      instr_address <= pc;
      alu_value     <= $signed(res.alu);
      dest_index    <= res.dest;
      writes_reg    <= res.wr;
      load_request  <= res.ld;
      store_request <= res.st;
      store_value   <= $signed(res.sval);
      branch_taken  <= res.taken;
      status        <= res.status;
    end
  end

  a_adv_shows: assert property (@(posedge clk) disable iff (rst)
    e_adv |=> result_valid && (instr_address == $past(pc)))
    else $error("Executed instruction did not reach the output register.");

  a_pc_step: assert property (@(posedge clk) disable iff (rst)
    e_adv && !res.taken |=> pc == $past(pc) + 32'd4)
    else $error("Program counter did not advance by four.");

  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> !writes_reg && !load_request && !store_request
      && !branch_taken && (dest_index == 5'd0))
    else $error("Rejected instruction produced side effects.");

  a_wr_dest: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.idx != 5'd0) && e_valid)
    else $error("Register file write to x0 or without an instruction.");

endmodule

// ===== src/rvsde_regfile.sv =====
// Register file held in a synchronous two-read, one-write memory with write forwarding.
`timescale 1ns / 1ps

module rvsde_regfile #(
  parameter int REG_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [4:0]        rs1,
  input  logic [4:0]        rs2,
  input  rvsde_pkg::wr_t    wr,
  output logic [31:0]       a,
  output logic [31:0]       b
);
  import rvsde_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [31:0]          q1;
  logic [31:0]          q2;
  logic                 ok1;
  logic                 ok2;
  logic                 fwd1;
  logic                 fwd2;
  logic [31:0]          fdata;
  logic                 rs1_in;
  logic                 rs2_in;
  logic                 wr_in;

  assign rs1_in = int'(rs1) < REG_COUNT;
  assign rs2_in = int'(rs2) < REG_COUNT;
  assign wr_in  = wr.en && (int'(wr.idx) < REG_COUNT);

  always_ff @(posedge clk) begin
    if (wr_in) begin
      mem[wr.idx[IDX_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      q1 <= mem[rs1[IDX_W-1:0]];
      q2 <= mem[rs2[IDX_W-1:0]];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_in) begin
      vld[wr.idx[IDX_W-1:0]] <= 1'b1;
    end
  end

  // A write at the same edge as the read is not seen by the memory, so it is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ok1   <= rs1_in && vld[rs1[IDX_W-1:0]];
      ok2   <= rs2_in && vld[rs2[IDX_W-1:0]];
      fwd1  <= wr_in && (wr.idx == rs1);
      fwd2  <= wr_in && (wr.idx == rs2);
      fdata <= wr.data;
    end
  end

  assign a = fwd1 ? fdata : (ok1 ? q1 : 32'd0);
  assign b = fwd2 ? fdata : (ok2 ? q2 : 32'd0);

endmodule

// ===== src/rvsde_exec.sv =====
// Instruction decode, ALU, address generation and branch resolution.
`timescale 1ns / 1ps

module rvsde_exec #(
  parameter int REG_COUNT = 32
) (
  input  logic [31:0]     instr,
  input  logic [31:0]     pc,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output rvsde_pkg::res_t res,
  output logic [31:0]     next_pc
);
  import rvsde_pkg::*;

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic        rd_ok;
  logic        lt;

  assign op    = instr[6:0];
  assign rd    = instr[11:7];
  assign f3    = instr[14:12];
  assign f7    = instr[31:25];
  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign rd_ok = (rd != 5'd0) && (int'(rd) < REG_COUNT);
  assign lt    = $signed(a) < $signed(b);

  always_comb begin
    res        = '0;
    res.status = ST_OK;
    next_pc    = pc + 32'd4;
    case (op)
      OP_R: begin
        if (f7 == F7_ALT && f3 == F3_ADD) begin
          res.alu = a - b;
        end else if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  res.alu = a + b;
            F3_AND:  res.alu = a & b;
            F3_OR:   res.alu = a | b;
            F3_XOR:  res.alu = a ^ b;
            F3_SLT:  res.alu = {31'd0, lt};
            default: res.status = ST_BAD_FUNCT;
          endcase
        end else begin
          res.status = ST_BAD_FUNCT;
        end
        if (res.status == ST_OK) begin
          res.dest = rd;
          res.wr   = rd_ok;
        end
      end
      OP_IMM: begin
        if (f3 == F3_ADD) begin
          res.alu  = a + imm_i;
          res.dest = rd;
          res.wr   = rd_ok;
        end else begin
          res.status = ST_BAD_FUNCT;
        end
      end
      OP_LOAD: begin
        case (f3)
          F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: begin
            res.alu  = a + imm_i;
            res.dest = rd;
            res.ld   = 1'b1;
          end
          default: res.status = ST_BAD_FUNCT;
        endcase
      end
      OP_STORE: begin
        case (f3)
          F3_SB, F3_SH, F3_SW: begin
            res.alu  = a + imm_s;
            res.st   = 1'b1;
            res.sval = b;
          end
          default: res.status = ST_BAD_FUNCT;
        endcase
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ, F3_BNE, F3_BLT, F3_BGE: begin
            res.alu = pc + imm_b;
            case (f3)
              F3_BEQ:  res.taken = (a == b);
              F3_BNE:  res.taken = (a != b);
              F3_BLT:  res.taken = lt;
              default: res.taken = !lt;
            endcase
            if (res.taken) begin
              next_pc = res.alu;
            end
          end
          default: res.status = ST_BAD_FUNCT;
        endcase
      end
      default: res.status = ST_BAD_OP;
    endcase
  end

endmodule

// ===== dv/rv32i_subset_decode_execute_unit_tb.sv =====
// Self-checking testbench for the RV32I subset decode and execute unit.
`timescale 1ns / 1ps

module rv32i_subset_decode_execute_unit_tb;
  import rvsde_pkg::*;

  localparam int REG_COUNT       = 32;
  localparam int RANDOM_ITEMS    = 1200;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int DRAIN_CYCLES    = 8;

  // Encodings that the unit must reject with a funct status.
  localparam logic [6:0] F7_BAD        = 7'b0000001;
  localparam logic [2:0] F3_BAD_R      = 3'b001;
  localparam logic [2:0] F3_BAD_IMM    = 3'b001;
  localparam logic [2:0] F3_BAD_LOAD   = 3'b011;
  localparam logic [2:0] F3_BAD_STORE  = 3'b011;
  localparam logic [2:0] F3_BAD_BRANCH = 3'b010;

  typedef struct packed {
    logic [31:0] pc;
    res_t        r;
  } exec_outcome_t;

  typedef struct {
    logic [31:0]   word;
    bit            typed;
    exec_outcome_t want;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               instr_valid = 1'b0;
  logic               instr_stall;
  logic [31:0]        instruction = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [31:0]        instr_address;
  logic signed [31:0] alu_value;
  logic [4:0]         dest_index;
  logic               writes_reg;
  logic               load_request;
  logic               store_request;
  logic signed [31:0] store_value;
  logic               branch_taken;
  logic [1:0]         status;

  // Travels with the instruction so the monitor knows whether a fixed result applies.
  bit                 row_typed = 1'b0;
  exec_outcome_t      row_want = '0;

  logic [31:0]        arch_regs [32];
  logic [31:0]        arch_pc;
  exec_outcome_t      pending_outcomes [$];
  stim_row_t          stim_rows [$];
  int                 fail_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_off_request = 1'b0;

  rv32i_subset_decode_execute_unit #(
    .REG_COUNT(REG_COUNT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instruction  (instruction),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .instr_address(instr_address),
    .alu_value    (alu_value),
    .dest_index   (dest_index),
    .writes_reg   (writes_reg),
    .load_request (load_request),
    .store_request(store_request),
    .store_value  (store_value),
    .branch_taken (branch_taken),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL rv32i_subset_decode_execute_unit");
    $finish;
  end

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OP_R};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] gpr_read(input logic [4:0] idx);
    if (idx == 5'd0 || idx >= REG_COUNT) return '0;
    return arch_regs[idx];
  endfunction

  function automatic logic gpr_write(input logic [4:0] idx, input logic [31:0] val);
    if (idx == 5'd0 || idx >= REG_COUNT) return 1'b0;
    arch_regs[idx] = val;
    return 1'b1;
  endfunction

  // Executes one instruction against the architectural state and returns its outcome.
  function automatic exec_outcome_t predict_exec(input logic [31:0] word);
    logic [6:0]    opc;
    logic [6:0]    f7;
    logic [2:0]    f3;
    logic [4:0]    rd;
    logic [31:0]   a;
    logic [31:0]   b;
    logic [31:0]   imm_i;
    logic [31:0]   imm_s;
    logic [31:0]   imm_b;
    logic [31:0]   nxt;
    logic          ok;
    exec_outcome_t o;
    opc   = word[6:0];
    rd    = word[11:7];
    f3    = word[14:12];
    f7    = word[31:25];
    a     = gpr_read(word[19:15]);
    b     = gpr_read(word[24:20]);
    imm_i = {{20{word[31]}}, word[31:20]};
    imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    o     = '0;
    o.pc  = arch_pc;
    nxt   = arch_pc + 32'd4;
    ok    = 1'b1;
    case (opc)
      OP_R: begin
        if (f7 == F7_BASE && f3 == F3_ADD) o.r.alu = a + b;
        else if (f7 == F7_ALT && f3 == F3_ADD) o.r.alu = a - b;
        else if (f7 == F7_BASE && f3 == F3_AND) o.r.alu = a & b;
        else if (f7 == F7_BASE && f3 == F3_OR) o.r.alu = a | b;
        else if (f7 == F7_BASE && f3 == F3_XOR) o.r.alu = a ^ b;
        else if (f7 == F7_BASE && f3 == F3_SLT) o.r.alu = {31'd0, $signed(a) < $signed(b)};
        else ok = 1'b0;
        if (ok) begin
          o.r.dest = rd;
          o.r.wr   = gpr_write(rd, o.r.alu);
        end else begin
          o.r.status = ST_BAD_FUNCT;
        end
      end
      OP_IMM: begin
        if (f3 == F3_ADD) begin
          o.r.alu  = a + imm_i;
          o.r.dest = rd;
          o.r.wr   = gpr_write(rd, o.r.alu);
        end else begin
          o.r.status = ST_BAD_FUNCT;
        end
      end
      OP_LOAD: begin
        if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU) begin
          o.r.alu  = a + imm_i;
          o.r.dest = rd;
          o.r.ld   = 1'b1;
        end else begin
          o.r.status = ST_BAD_FUNCT;
        end
      end
      OP_STORE: begin
        if (f3 == F3_SB || f3 == F3_SH || f3 == F3_SW) begin
          o.r.alu  = a + imm_s;
          o.r.st   = 1'b1;
          o.r.sval = b;
        end else begin
          o.r.status = ST_BAD_FUNCT;
        end
      end
      OP_BRANCH: begin
        if (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT || f3 == F3_BGE) begin
          o.r.alu = arch_pc + imm_b;
          case (f3)
            F3_BEQ:  o.r.taken = (a == b);
            F3_BNE:  o.r.taken = (a != b);
            F3_BLT:  o.r.taken = ($signed(a) < $signed(b));
            default: o.r.taken = !($signed(a) < $signed(b));
          endcase
          if (o.r.taken) nxt = o.r.alu;
        end else begin
          o.r.status = ST_BAD_FUNCT;
        end
      end
      default: o.r.status = ST_BAD_OP;
    endcase
    arch_pc = nxt;
    return o;
  endfunction

  function automatic exec_outcome_t typed_outcome(input logic [31:0] pc, input logic [31:0] alu,
                                                  input logic [4:0] dest, input logic wr,
                                                  input logic [1:0] st);
    exec_outcome_t o;
    o          = '0;
    o.pc       = pc;
    o.r.alu    = alu;
    o.r.dest   = dest;
    o.r.wr     = wr;
    o.r.status = st;
    return o;
  endfunction

  function automatic logic [4:0] pick_reg();
    // A small working set keeps back-to-back dependencies frequent.
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] gen_random_word();
    int unsigned pick;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rs1;
    pick = $urandom_range(0, 99);
    f3   = 3'($urandom_range(0, 7));
    f7   = F7_BASE;
    if (pick < 25) begin
      case ($urandom_range(0, 6))
        0: f3 = F3_ADD;
        1: begin
          f7 = F7_ALT;
          f3 = F3_ADD;
        end
        2: f3 = F3_AND;
        3: f3 = F3_OR;
        4: f3 = F3_XOR;
        5: f3 = F3_SLT;
        default: if ($urandom_range(0, 1) == 0) f7 = 7'($urandom_range(0, 127));
      endcase
      return enc_r(f7, f3, pick_reg(), pick_reg(), pick_reg());
    end
    if (pick < 45) begin
      if ($urandom_range(0, 4) != 0) f3 = F3_ADD;
      return enc_i(OP_IMM, f3, pick_reg(), pick_reg(), 12'($urandom_range(0, 4095)));
    end
    if (pick < 55) begin
      return enc_i(OP_LOAD, f3, pick_reg(), pick_reg(), 12'($urandom_range(0, 4095)));
    end
    if (pick < 65) return enc_s(f3, pick_reg(), pick_reg(), 12'($urandom_range(0, 4095)));
    if (pick < 82) begin
      rs1 = pick_reg();
      return enc_b(f3, rs1, ($urandom_range(0, 2) == 0) ? rs1 : pick_reg(),
                   {12'($urandom_range(0, 4095)), 1'b0});
    end
    return $urandom;
  endfunction

  task automatic add_row(input logic [31:0] word, input bit typed, input exec_outcome_t want);
    stim_row_t row;
    row.word  = word;
    row.typed = typed;
    row.want  = want;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [31:0] word, input bit typed,
                              input exec_outcome_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      instr_valid <= 1'b0;
      @(negedge clk);
    end
    instr_valid <= 1'b1;
    instruction <= word;
    row_typed   <= typed;
    row_want    <= want;
    do @(posedge clk); while (instr_stall);
    @(negedge clk);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %h, want %h at %0t ns", what, got, want, $time);
    fail_count++;
  endtask

  task automatic check_outcome(input exec_outcome_t exp);
    if (instr_address !== exp.pc) report("instr_address", instr_address, exp.pc);
    if (alu_value !== exp.r.alu) report("alu_value", alu_value, exp.r.alu);
    if (dest_index !== exp.r.dest) begin
      report("dest_index", 32'(dest_index), 32'(exp.r.dest));
    end
    if (writes_reg !== exp.r.wr) report("writes_reg", 32'(writes_reg), 32'(exp.r.wr));
    if (load_request !== exp.r.ld) report("load_request", 32'(load_request), 32'(exp.r.ld));
    if (store_request !== exp.r.st) begin
      report("store_request", 32'(store_request), 32'(exp.r.st));
    end
    if (store_value !== exp.r.sval) report("store_value", store_value, exp.r.sval);
    if (branch_taken !== exp.r.taken) begin
      report("branch_taken", 32'(branch_taken), 32'(exp.r.taken));
    end
    if (status !== exp.r.status) report("status", 32'(status), 32'(exp.r.status));
  endtask

  always @(posedge clk) begin : monitor_b
    exec_outcome_t predicted;
    if (!rst) begin
      if (instr_valid && !instr_stall) begin
        predicted = predict_exec(instruction);
        pending_outcomes.insert(pending_outcomes.size(), row_typed ? row_want : predicted);
      end
      if (result_valid && !result_stall) begin
        if (pending_outcomes.size() == 0) report("result with nothing pending", instr_address, '0);
        else check_outcome(pending_outcomes.pop_front());
      end
    end
  end

  initial begin : result_side_b
    @(negedge clk);
    forever begin
      if (hold_off_request) begin
        // Long hold-off so the unit fills up and pushes back on its input.
        hold_off_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus_b
    int n;
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_pc = '0;

    // Rows with a fixed result start from the reset state.
    add_row(enc_r(F7_BASE, F3_ADD, 5'd1, 5'd0, 5'd0), 1'b1,
            typed_outcome(32'd0, 32'd0, 5'd1, 1'b1, ST_OK));
    add_row(32'hFFFF_FFFF, 1'b1, typed_outcome(32'd4, 32'd0, 5'd0, 1'b0, ST_BAD_OP));
    add_row(enc_i(OP_IMM, F3_ADD, 5'd2, 5'd0, 12'h800), 1'b1,
            typed_outcome(32'd8, 32'hFFFF_F800, 5'd2, 1'b1, ST_OK));
    add_row(enc_i(OP_IMM, F3_ADD, 5'd3, 5'd0, 12'h7FF), 1'b1,
            typed_outcome(32'd12, 32'h0000_07FF, 5'd3, 1'b1, ST_OK));
    add_row(enc_r(F7_BAD, F3_ADD, 5'd5, 5'd2, 5'd3), 1'b1,
            typed_outcome(32'd16, 32'd0, 5'd0, 1'b0, ST_BAD_FUNCT));
    add_row(enc_i(OP_IMM, F3_BAD_IMM, 5'd5, 5'd2, 12'h001), 1'b1,
            typed_outcome(32'd20, 32'd0, 5'd0, 1'b0, ST_BAD_FUNCT));
    add_row(enc_r(F7_ALT, F3_ADD, 5'd4, 5'd2, 5'd3), 1'b0, '0);
    add_row(enc_r(F7_BASE, F3_AND, 5'd5, 5'd2, 5'd3), 1'b0, '0);
    add_row(enc_r(F7_BASE, F3_OR, 5'd6, 5'd2, 5'd3), 1'b0, '0);
    add_row(enc_r(F7_BASE, F3_XOR, 5'd7, 5'd2, 5'd3), 1'b0, '0);
    add_row(enc_r(F7_BASE, F3_SLT, 5'd8, 5'd2, 5'd3), 1'b0, '0);
    add_row(enc_r(F7_BASE, F3_ADD, 5'd0, 5'd2, 5'd3), 1'b0, '0);
    add_row(enc_r(F7_BASE, F3_ADD, 5'd31, 5'd4, 5'd4), 1'b0, '0);
    add_row(enc_r(F7_BASE, F3_BAD_R, 5'd9, 5'd2, 5'd3), 1'b0, '0);
    add_row(enc_i(OP_LOAD, F3_LW, 5'd10, 5'd2, 12'hFFF), 1'b0, '0);
    add_row(enc_i(OP_LOAD, F3_LBU, 5'd11, 5'd31, 12'h7FF), 1'b0, '0);
    add_row(enc_i(OP_LOAD, F3_BAD_LOAD, 5'd11, 5'd3, 12'h010), 1'b0, '0);
    add_row(enc_s(F3_SW, 5'd3, 5'd31, 12'h800), 1'b0, '0);
    add_row(enc_s(F3_SB, 5'd0, 5'd2, 12'h005), 1'b0, '0);
    add_row(enc_s(F3_BAD_STORE, 5'd3, 5'd2, 12'h004), 1'b0, '0);
    add_row(enc_b(F3_BEQ, 5'd3, 5'd3, 13'h1000), 1'b0, '0);
    add_row(enc_b(F3_BNE, 5'd2, 5'd3, 13'h0FFE), 1'b0, '0);
    add_row(enc_b(F3_BLT, 5'd3, 5'd2, 13'h0008), 1'b0, '0);
    add_row(enc_b(F3_BGE, 5'd3, 5'd2, 13'h1FF8), 1'b0, '0);
    add_row(enc_b(F3_BAD_BRANCH, 5'd3, 5'd2, 13'h0010), 1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct  = 19;
    recv_stall_pct = 81;
    foreach (stim_rows[i]) send_request(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct  = 81;
        recv_stall_pct = 19;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = 1'b1;
      end
      send_request(gen_random_word(), 1'b0, '0);
    end
    instr_valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS rv32i_subset_decode_execute_unit");
    end else begin
      $display("FAIL rv32i_subset_decode_execute_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rvsde_pkg.sv
src/rvsde_regfile.sv
src/rvsde_exec.sv
src/rv32i_subset_decode_execute_unit.sv
dv/rv32i_subset_decode_execute_unit_tb.sv
